[hdl/tfb_pkg.sv]
`timescale 1ns / 1ps
// Shared constants, types and the arctangent table for the tilt fusion block.
// No dependencies; used by tfb_cordic, tfb_mac and tilt_fusion_balance_control.
package tfb_pkg;

	localparam int CORDIC_STEPS = 16;
	localparam int ATAN_ENTRIES = 24;
	localparam int CORDIC_ITERS = (CORDIC_STEPS < ATAN_ENTRIES) ? CORDIC_STEPS : ATAN_ENTRIES;
	localparam int ITER_W       = $clog2(CORDIC_ITERS);
	localparam int ATAN_IDX_W   = $clog2(ATAN_ENTRIES);

	localparam int SAMPLE_W = 16;
	localparam int XY_W     = 36;
	localparam int TILT_W   = 25;
	localparam int ANGLE_W  = 24;
	localparam int MUL_A_W  = 26;
	localparam int MUL_B_W  = 18;
	localparam int ACC_W    = 45;
	localparam int REG_W    = 16;
	localparam int DRIVE_W  = 16;

	typedef logic signed [TILT_W-1:0]  tilt_t;
	typedef logic signed [ANGLE_W-1:0] angle_t;
	typedef logic signed [ACC_W-1:0]   acc_t;

	localparam tilt_t                      PI_Q20       = 25'sd3294199;
	localparam angle_t                     PI32_Q20     = 24'sd102943;
	localparam logic signed [MUL_B_W-1:0]  GYRO_K       = 18'sd52458;
	localparam logic signed [MUL_B_W-1:0]  WEIGHT_ONE   = 18'sd65536;
	localparam logic [REG_W-1:0]           WEIGHT_RESET = 16'd64225;
	localparam logic [REG_W-1:0]           GAIN_RESET   = 16'd0;

	typedef struct packed {
		logic en;
		logic clr;
	} mac_ctl_t;

	typedef enum logic {
		REG_WEIGHT = 1'b0,
		REG_GAIN   = 1'b1
	} reg_idx_t;

	// atan(2^-i) in Q3.20, rounded to nearest
	function automatic tilt_t atan_q20(input logic [ATAN_IDX_W-1:0] idx);
		tilt_t r;
		case (idx)
			5'd0:    r = 25'sd823550;
			5'd1:    r = 25'sd486170;
			5'd2:    r = 25'sd256879;
			5'd3:    r = 25'sd130396;
			5'd4:    r = 25'sd65451;
			5'd5:    r = 25'sd32757;
			5'd6:    r = 25'sd16383;
			5'd7:    r = 25'sd8192;
			5'd8:    r = 25'sd4096;
			5'd9:    r = 25'sd2048;
			5'd10:   r = 25'sd1024;
			5'd11:   r = 25'sd512;
			5'd12:   r = 25'sd256;
			5'd13:   r = 25'sd128;
			5'd14:   r = 25'sd64;
			5'd15:   r = 25'sd32;
			5'd16:   r = 25'sd16;
			5'd17:   r = 25'sd8;
			5'd18:   r = 25'sd4;
			5'd19:   r = 25'sd2;
			5'd20:   r = 25'sd1;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

[hdl/tfb_cordic.sv]
`timescale 1ns / 1ps
// Iterative vectoring CORDIC: atan2(accel_x, accel_z) in Q3.20, one step per cycle.
// Depends on tfb_pkg.
module tfb_cordic (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic signed [15:0]         accel_x,
	input  logic signed [15:0]         accel_z,
	output tfb_pkg::tilt_t             tilt,
	output logic                       busy,
	output logic                       done
);

	logic signed [tfb_pkg::XY_W-1:0] x_q, y_q, dx, dy, ax_w, az_w;
	tfb_pkg::tilt_t                  z_q, step_ang;
	logic [tfb_pkg::ITER_W-1:0]      i_q;
	logic                            run_q, done_q, zero_vec, last_step;

	assign ax_w      = {{(tfb_pkg::XY_W-16){accel_x[15]}}, accel_x} <<< 16;
	assign az_w      = {{(tfb_pkg::XY_W-16){accel_z[15]}}, accel_z} <<< 16;
	assign zero_vec  = (accel_x == '0) && (accel_z == '0);
	assign last_step = (i_q == tfb_pkg::ITER_W'(tfb_pkg::CORDIC_ITERS - 1));
	assign dx        = y_q >>> i_q;
	assign dy        = x_q >>> i_q;
	assign step_ang  = tfb_pkg::atan_q20(tfb_pkg::ATAN_IDX_W'(i_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			i_q    <= '0;
		end else if (start) begin
			run_q  <= !zero_vec;
			done_q <= zero_vec;
			i_q    <= '0;
		end else if (run_q) begin
			i_q <= i_q + 1'b1;
			if (last_step) begin
				run_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			if (zero_vec) begin
				x_q <= '0;
				y_q <= '0;
				z_q <= '0;
			end else if (accel_z < 0) begin
				// left half plane: rotate by pi first
				x_q <= -az_w;
				y_q <= -ax_w;
				z_q <= (accel_x >= 0) ? tfb_pkg::PI_Q20 : -tfb_pkg::PI_Q20;
			end else begin
				x_q <= az_w;
				y_q <= ax_w;
				z_q <= '0;
			end
		end else if (run_q) begin
			if (!y_q[tfb_pkg::XY_W-1]) begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				z_q <= z_q + step_ang;
			end else begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				z_q <= z_q - step_ang;
			end
		end
	end

	assign tilt = z_q;
	assign busy = run_q;
	assign done = done_q;

endmodule

[hdl/tfb_mac.sv]
`timescale 1ns / 1ps
// Shared multiply-accumulate unit: one registered signed product per cycle while ctl.en is set.
// Depends on tfb_pkg.
module tfb_mac (
	input  logic                               clk,
	input  tfb_pkg::mac_ctl_t                  ctl,
	input  logic signed [tfb_pkg::MUL_A_W-1:0] op_a,
	input  logic signed [tfb_pkg::MUL_B_W-1:0] op_b,
	output tfb_pkg::acc_t                      acc
);

	logic signed [tfb_pkg::MUL_A_W+tfb_pkg::MUL_B_W-1:0] prod;
	tfb_pkg::acc_t                                      acc_q;

	assign prod = op_a * op_b;

	always_ff @(posedge clk) begin
		if (ctl.en) begin
			acc_q <= (ctl.clr ? tfb_pkg::acc_t'(0) : acc_q) + tfb_pkg::acc_t'(prod);
		end
	end

	assign acc = acc_q;

endmodule

[hdl/tilt_fusion_balance_control.sv]
`timescale 1ns / 1ps
// Tilt fusion balance control: top level with sequencer, config registers and output stage.
// Depends on tfb_pkg, tfb_cordic and tfb_mac.
//
// Usage: one raw IMU sample enters on the s_ stream (accel X, accel Z, gyro Y). The block
// finds the accelerometer tilt with an iterative CORDIC, blends it with the integrated gyro
// rate in a complementary filter and returns one result on the m_ stream: a saturated
// proportional drive level, a forward/backward bit and the fused tilt angle (Q3.20 rad).
// The sequencer scales the gyro rate, adds it to the fused angle, weights that sum, adds the
// weighted CORDIC tilt (one add/shift step per cycle), rounds and forms the drive product;
// one multiplier is shared for the gyro scaling, both filter terms and the drive product.
// A zero accel vector skips the CORDIC loop. s_tready is high only while the sequencer is
// idle, so a new sample is accepted only after the previous one has left the sequencer.
// A finished result sits in the output register; the next sample is accepted meanwhile,
// and the sequencer holds its new result until the receiver has taken the old one.
// Reset clears the fused angle to zero, fusion_weight to 0.98 and prop_gain to zero.
// Registers sit on the APB port at byte 0 (fusion_weight) and byte 4 (prop_gain);
// write them only while the block is idle.
module tilt_fusion_balance_control (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // accel_x[15:0], accel_z[31:16], gyro_y[47:32]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // drive_level[15:0], forward[16], tilt_angle[40:17], zero pad
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_GYRO,
		S_INC,
		S_MW,
		S_WAIT,
		S_ROUND,
		S_DRV,
		S_OUT
	} state_t;

	state_t                                 state_q;
	logic [tfb_pkg::REG_W-1:0]              weight_q, gain_q;
	logic signed [tfb_pkg::SAMPLE_W-1:0]    gyro_q;
	tfb_pkg::angle_t                        fused_q;
	logic signed [tfb_pkg::TILT_W-1:0]      sum_q;
	logic signed [tfb_pkg::DRIVE_W-1:0]     drive_q;
	logic                                   fwd_q, m_tvalid_q;
	tfb_pkg::angle_t                        tilt_out_q;

	logic                                   accept, cfg_wr, out_free;
	logic                                   cordic_busy, cordic_done;
	tfb_pkg::tilt_t                         cordic_tilt;
	tfb_pkg::mac_ctl_t                      mac_ctl;
	logic signed [tfb_pkg::MUL_A_W-1:0]     mac_a;
	logic signed [tfb_pkg::MUL_B_W-1:0]     mac_b;
	tfb_pkg::acc_t                          acc, sh16, sh20;
	tfb_pkg::angle_t                        angle_sat;
	logic signed [tfb_pkg::DRIVE_W-1:0]     drive_sat;
	logic signed [tfb_pkg::MUL_B_W-1:0]     weight_s, gain_s;

	assign accept   = s_tvalid && s_tready;
	assign s_tready = (state_q == S_IDLE);
	assign out_free = !m_tvalid_q || m_tready;
	assign weight_s = {2'b00, weight_q};
	assign gain_s   = {2'b00, gain_q};

	tfb_cordic u_cordic (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (accept),
		.accel_x (s_tdata[15:0]),
		.accel_z (s_tdata[31:16]),
		.tilt    (cordic_tilt),
		.busy    (cordic_busy),
		.done    (cordic_done)
	);

	// operand select for the shared multiplier
	always_comb begin
		mac_ctl = '0;
		mac_a   = '0;
		mac_b   = '0;
		case (state_q)
			S_GYRO: begin
				mac_ctl = '{en: 1'b1, clr: 1'b1};
				mac_a   = {{(tfb_pkg::MUL_A_W-tfb_pkg::SAMPLE_W){gyro_q[15]}}, gyro_q};
				mac_b   = tfb_pkg::GYRO_K;
			end
			S_MW: begin
				mac_ctl = '{en: 1'b1, clr: 1'b1};
				mac_a   = {sum_q[tfb_pkg::TILT_W-1], sum_q};
				mac_b   = weight_s;
			end
			S_WAIT: begin
				// accumulate the accelerometer term onto the weighted sum of fused angle and gyro term
				mac_ctl = '{en: cordic_done, clr: 1'b0};
				mac_a   = {cordic_tilt[tfb_pkg::TILT_W-1], cordic_tilt};
				mac_b   = tfb_pkg::WEIGHT_ONE - weight_s;
			end
			S_DRV: begin
				mac_ctl = '{en: 1'b1, clr: 1'b1};
				mac_a   = {{(tfb_pkg::MUL_A_W-tfb_pkg::ANGLE_W){fused_q[tfb_pkg::ANGLE_W-1]}},
				           fused_q};
				mac_b   = gain_s;
			end
			default: begin
				mac_ctl = '0;
			end
		endcase
	end

	tfb_mac u_mac (
		.clk  (clk),
		.ctl  (mac_ctl),
		.op_a (mac_a),
		.op_b (mac_b),
		.acc  (acc)
	);

	// round half up, then saturate
	assign sh16 = (acc + tfb_pkg::acc_t'(32768)) >>> 16;
	assign sh20 = (acc + tfb_pkg::acc_t'(524288)) >>> 20;

	always_comb begin
		if (sh16[tfb_pkg::ACC_W-1:tfb_pkg::ANGLE_W-1] == '0 ||
		    sh16[tfb_pkg::ACC_W-1:tfb_pkg::ANGLE_W-1] == '1) begin
			angle_sat = sh16[tfb_pkg::ANGLE_W-1:0];
		end else if (sh16[tfb_pkg::ACC_W-1]) begin
			angle_sat = {1'b1, {(tfb_pkg::ANGLE_W-1){1'b0}}};
		end else begin
			angle_sat = {1'b0, {(tfb_pkg::ANGLE_W-1){1'b1}}};
		end
	end

	always_comb begin
		if (sh20[tfb_pkg::ACC_W-1:tfb_pkg::DRIVE_W-1] == '0 ||
		    sh20[tfb_pkg::ACC_W-1:tfb_pkg::DRIVE_W-1] == '1) begin
			drive_sat = sh20[tfb_pkg::DRIVE_W-1:0];
		end else if (sh20[tfb_pkg::ACC_W-1]) begin
			drive_sat = {1'b1, {(tfb_pkg::DRIVE_W-1){1'b0}}};
		end else begin
			drive_sat = {1'b0, {(tfb_pkg::DRIVE_W-1){1'b1}}};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			fused_q    <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (state_q == S_OUT && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_GYRO;
					end
				end
				S_GYRO:  state_q <= S_INC;
				S_INC:   state_q <= S_MW;
				S_MW:    state_q <= S_WAIT;
				S_WAIT: begin
					if (cordic_done) begin
						state_q <= S_ROUND;
					end
				end
				S_ROUND: begin
					fused_q <= angle_sat;
					state_q <= S_DRV;
				end
				S_DRV:   state_q <= S_OUT;
				S_OUT: begin
					// hold until the output register is free
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			gyro_q <= s_tdata[47:32];
		end
		if (state_q == S_INC) begin
			sum_q <= {fused_q[tfb_pkg::ANGLE_W-1], fused_q} + sh16[tfb_pkg::TILT_W-1:0];
		end
		if (state_q == S_OUT && out_free) begin
			drive_q    <= drive_sat;
			fwd_q      <= (fused_q <= tfb_pkg::PI32_Q20);
			tilt_out_q <= fused_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {7'b0, tilt_out_q, fwd_q, drive_q};

	// configuration registers
	assign cfg_wr = psel && penable && pwrite && pready;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			weight_q <= tfb_pkg::WEIGHT_RESET;
			gain_q   <= tfb_pkg::GAIN_RESET;
		end else if (cfg_wr) begin
			unique case (tfb_pkg::reg_idx_t'(paddr[2]))
				tfb_pkg::REG_WEIGHT: weight_q <= pwdata[tfb_pkg::REG_W-1:0];
				tfb_pkg::REG_GAIN:   gain_q   <= pwdata[tfb_pkg::REG_W-1:0];
				default:             weight_q <= weight_q;
			endcase
		end
	end

	always_comb begin
		unique case (tfb_pkg::reg_idx_t'(paddr[2]))
			tfb_pkg::REG_WEIGHT: prdata = {16'b0, weight_q};
			tfb_pkg::REG_GAIN:   prdata = {16'b0, gain_q};
			default:             prdata = '0;
		endcase
	end

	a_ready_cordic_idle: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !cordic_busy)
		else $error("input ready while CORDIC still iterating");

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == S_GYRO)
		else $error("accepted sample did not start the sequencer");

	a_forward_matches: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid_q) |-> (fwd_q == (tilt_out_q <= tfb_pkg::PI32_Q20)))
		else $error("direction bit disagrees with delivered angle");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_OUT && m_tvalid_q && !m_tready) |=> state_q == S_OUT)
		else $error("sequencer left output state while result stalled");

endmodule
